@@ rtl/quaternion_normalizer_defines.svh @@
// quaternion_normalizer_defines.svh: assertion macros for the quaternion normalizer
// used by quaternion_normalizer.sv, expects clk and rst_n in scope
`ifndef QUATERNION_NORMALIZER_DEFINES_SVH
`define QUATERNION_NORMALIZER_DEFINES_SVH

// implication checked in the same cycle
`define QN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quaternion_normalizer check failed");

// implication checked in the next cycle
`define QN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quaternion_normalizer check failed");

`endif

@@ rtl/qn_pkg.sv @@
// qn_pkg.sv: shared constants for the quaternion normalizer
// no dependencies
package qn_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int FRACTION_BITS_DEF   = 14;
  localparam int NUM_LANES           = 4;

endpackage

@@ rtl/qn_lane.sv @@
// qn_lane.sv: one component lane, bit-per-stage search for round(|c| * 2^F / sqrt(S))
// depends on qn_pkg
module qn_lane
  import qn_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int FRACTION_BITS   = FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [2*COMPONENT_WIDTH-1:0]     sq_i,
  input  logic [2*COMPONENT_WIDTH+1:0]     sum_i,
  input  logic                             neg_i,
  output logic [FRACTION_BITS:0]           mag_o,
  output logic                             neg_o
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int SW = 2*W + 2;
  localparam int QW = 2*W + 2*F + 6;

  logic signed [QW-1:0] p_init, q_init, s_init, t_init;

  // candidate r = 0, so q = 2r - 1 = -1, P = q^2 S, Q = q S
  assign s_init = $signed({{(QW-SW){1'b0}}, sum_i});
  assign p_init = s_init;
  assign q_init = -s_init;
  assign t_init = $signed({{(QW-2*W){1'b0}}, sq_i}) <<< (2*F + 2);

  logic signed [QW-1:0] p_r [0:F];
  logic signed [QW-1:0] q_r [0:F];
  logic signed [QW-1:0] s_r [0:F];
  logic signed [QW-1:0] t_r [0:F];
  logic [F:0]           r_r [0:F];
  logic                 neg_r [0:F];

  genvar j;
  generate
    for (j = 0; j <= F; j++) begin : g_stage
      localparam int K = F - j;
      logic signed [QW-1:0] p_in, q_in, s_in, t_in, p_try;
      logic [F:0]           r_in;
      logic                 n_in;
      logic signed [QW-1:0] p_nxt, q_nxt;
      logic [F:0]           r_nxt;

      if (j == 0) begin : g_first
        assign p_in = p_init;
        assign q_in = q_init;
        assign s_in = s_init;
        assign t_in = t_init;
        assign r_in = '0;
        assign n_in = neg_i;
      end else begin : g_next
        assign p_in = p_r[j-1];
        assign q_in = q_r[j-1];
        assign s_in = s_r[j-1];
        assign t_in = t_r[j-1];
        assign r_in = r_r[j-1];
        assign n_in = neg_r[j-1];
      end

      // (q + 2^(K+1))^2 S = P + Q 2^(K+2) + S 4^(K+1)
      assign p_try = p_in + (q_in <<< (K + 2)) + (s_in <<< (2*K + 2));

      always_comb begin
        if (p_try <= t_in) begin
          p_nxt = p_try;
          q_nxt = q_in + (s_in <<< (K + 1));
          r_nxt = r_in | ((F+1)'(1) << K);
        end else begin
          p_nxt = p_in;
          q_nxt = q_in;
          r_nxt = r_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          p_r[j]   <= p_nxt;
          q_r[j]   <= q_nxt;
          s_r[j]   <= s_in;
          t_r[j]   <= t_in;
          r_r[j]   <= r_nxt;
          neg_r[j] <= n_in;
        end
      end
    end
  endgenerate

  assign mag_o = r_r[F];
  assign neg_o = neg_r[F];

endmodule

@@ rtl/quaternion_normalizer.sv @@
// channel  ports                               direction
// in       in_valid in_stall in_w..in_z        transaction into the block
// out      out_valid out_stall out_w..out_z    transaction out, with out_zero_length
//
// one transaction per cycle while out_stall does not hold the pipeline
// the per-lane search resolves one result bit per pipeline stage
// reset (rst_n low, synchronous) empties the pipeline
// out_stall freezes the whole pipeline while a result waits; in_stall follows it
//
// quaternion_normalizer.sv: top level, magnitudes, squares, sum, four lanes, output merge
// depends on qn_pkg, qn_lane, quaternion_normalizer_defines.svh
`include "quaternion_normalizer_defines.svh"

module quaternion_normalizer
  import qn_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int FRACTION_BITS   = FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0] in_w,
  input  logic signed [COMPONENT_WIDTH-1:0] in_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [FRACTION_BITS+1:0]   out_w,
  output logic signed [FRACTION_BITS+1:0]   out_x,
  output logic signed [FRACTION_BITS+1:0]   out_y,
  output logic signed [FRACTION_BITS+1:0]   out_z,
  output logic                              out_zero_length
);

  localparam int W   = COMPONENT_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int SW  = 2*W + 2;
  localparam int OW  = F + 2;
  localparam int NST = F + 4;

  logic en;
  logic out_valid_r;
  logic [NST-1:0] vld_r;
  logic [F:0]     zero_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  logic [W-1:0] comp [NUM_LANES];
  assign comp[0] = in_w;
  assign comp[1] = in_x;
  assign comp[2] = in_y;
  assign comp[3] = in_z;

  logic [W-1:0]   mag_r  [NUM_LANES];
  logic           neg1_r [NUM_LANES];
  logic [2*W-1:0] sq_r   [NUM_LANES];
  logic           neg2_r [NUM_LANES];
  logic [2*W-1:0] sq3_r  [NUM_LANES];
  logic           neg3_r [NUM_LANES];
  logic [SW-1:0]  sum_r;
  logic           zero3_r;
  logic [SW-1:0]  sum_nxt;

  assign sum_nxt = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]) + SW'(sq_r[3]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        neg1_r[i] <= comp[i][W-1];
        mag_r[i]  <= comp[i][W-1] ? (~comp[i] + W'(1)) : comp[i];
        sq_r[i]   <= (2*W)'(mag_r[i]) * (2*W)'(mag_r[i]);
        neg2_r[i] <= neg1_r[i];
        sq3_r[i]  <= sq_r[i];
        neg3_r[i] <= neg2_r[i];
      end
      sum_r   <= sum_nxt;
      zero3_r <= (sum_nxt == '0);
    end
  end

  logic [F:0] lane_mag [NUM_LANES];
  logic       lane_neg [NUM_LANES];

  genvar g;
  generate
    for (g = 0; g < NUM_LANES; g++) begin : g_lane
      qn_lane #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH),
        .FRACTION_BITS   (FRACTION_BITS)
      ) u_lane (
        .clk   (clk),
        .en    (en),
        .sq_i  (sq3_r[g]),
        .sum_i (sum_r),
        .neg_i (neg3_r[g]),
        .mag_o (lane_mag[g]),
        .neg_o (lane_neg[g])
      );
    end
  endgenerate

  // valid and zero flag travel alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NST-2:0], in_valid};
      out_valid_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= {zero_r[F-1:0], zero3_r};
    end
  end

  // merge: sign, zero forcing, output register
  logic signed [OW-1:0] res_nxt [NUM_LANES];
  logic signed [OW-1:0] res_r   [NUM_LANES];
  logic                 zl_r;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (zero_r[F]) begin
        res_nxt[i] = '0;
      end else if (lane_neg[i]) begin
        res_nxt[i] = -$signed({1'b0, lane_mag[i]});
      end else begin
        res_nxt[i] = $signed({1'b0, lane_mag[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        res_r[i] <= res_nxt[i];
      end
      zl_r <= zero_r[F];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_w           = res_r[0];
  assign out_x           = res_r[1];
  assign out_y           = res_r[2];
  assign out_z           = res_r[3];
  assign out_zero_length = zl_r;

  `QN_ASSERT_NOW(a_zero_forces_zero, out_valid_r && zl_r,
    res_r[0] == '0 && res_r[1] == '0 && res_r[2] == '0 && res_r[3] == '0)
  `QN_ASSERT_NOW(a_nonzero_has_output, out_valid_r && !zl_r,
    res_r[0] != '0 || res_r[1] != '0 || res_r[2] != '0 || res_r[3] != '0)
  `QN_ASSERT_NEXT(a_stall_freezes_pipe, out_valid_r && out_stall,
    $stable(vld_r) && $stable(zero_r))

endmodule

@@ tb/sv/quaternion_normalizer_checker.sv @@
// quaternion_normalizer_checker.sv: predicts and checks the unit quaternion for every transaction
// watches both channels of quaternion_normalizer, depends on qn_pkg
`timescale 1ns / 100ps

module quaternion_normalizer_checker
  import qn_pkg::*;
#(
  parameter int CW = COMPONENT_WIDTH_DEF,
  parameter int FB = FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [CW-1:0]       in_w,
  input  logic signed [CW-1:0]       in_x,
  input  logic signed [CW-1:0]       in_y,
  input  logic signed [CW-1:0]       in_z,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [FB+1:0]       out_w,
  input  logic signed [FB+1:0]       out_x,
  input  logic signed [FB+1:0]       out_y,
  input  logic signed [FB+1:0]       out_z,
  input  logic                       out_zero_length,
  output int                         errors,
  output int                         pending
);

  typedef logic signed [FB+1:0] comp_t;
  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
    logic  zl;
  } unit_quat_t;

  unit_quat_t unit_q[$];

  function automatic comp_t scale_lane(logic signed [CW-1:0] c, logic [127:0] sum_sq);
    logic [127:0] mag, target, t;
    logic [63:0] lo, hi, mid;
    mag = (c < 0) ? 128'(-66'(c)) : 128'(c);
    target = (mag * mag) << (2 * FB + 2);
    lo = 0;
    hi = 64'(1) << FB;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = 128'(2 * mid - 1);
      if (t * t * sum_sq <= target) lo = mid;
      else hi = mid - 1;
    end
    return (c < 0) ? -comp_t'(lo) : comp_t'(lo);
  endfunction

  function automatic unit_quat_t normalize(logic signed [CW-1:0] w, logic signed [CW-1:0] x,
                                           logic signed [CW-1:0] y, logic signed [CW-1:0] z);
    logic [127:0] s;
    unit_quat_t r;
    s = 128'(64'(w) * 64'(w)) + 128'(64'(x) * 64'(x)) + 128'(64'(y) * 64'(y))
      + 128'(64'(z) * 64'(z));
    if (s == 0) begin
      r = '{0, 0, 0, 0, 1'b1};
    end else begin
      r = '{scale_lane(w, s), scale_lane(x, s), scale_lane(y, s), scale_lane(z, s), 1'b0};
    end
    return r;
  endfunction

  always @(posedge clk) begin
    unit_quat_t got, exp_q;
    if (!rst_n) begin
      errors <= 0;
    end else begin
      if (in_valid && !in_stall) unit_q.push_back(normalize(in_w, in_x, in_y, in_z));
      if (out_valid && !out_stall) begin
        got = '{out_w, out_x, out_y, out_z, out_zero_length};
        if (unit_q.size() == 0) begin
          if (errors < 10) $display("mismatch: unexpected transaction %p", got);
          errors <= errors + 1;
        end else begin
          exp_q = unit_q.pop_front();
          if (got !== exp_q) begin
            if (errors < 10) $display("mismatch: expected %p actual %p", exp_q, got);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= unit_q.size();
  end

endmodule

@@ tb/sv/quaternion_normalizer_tb.sv @@
// quaternion_normalizer_tb.sv: stimulus and verdict for the quaternion normalizer
// depends on quaternion_normalizer and quaternion_normalizer_checker
`timescale 1ns / 100ps

module quaternion_normalizer_tb;
  import qn_pkg::*;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall, out_zero_length;
  logic signed [15:0] in_w, in_x, in_y, in_z, out_w, out_x, out_y, out_z;
  int errors, pending;
  int send_idle, recv_stall;

  quaternion_normalizer DUT (.*);
  quaternion_normalizer_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL quaternion_normalizer");
    $finish;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall);

  function automatic logic signed [15:0] pick_comp();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 0;
      3: return $signed(16'($urandom_range(8) - 4));
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic send_quat(logic signed [15:0] w, x, y, z);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_w <= w;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    logic signed [15:0] corners[7];
    corners = '{16'sh8000, 16'sh7fff, 0, 1, -1, 16'sh4000, 16'shc000};
    rst_n = 0;
    in_valid = 0;
    in_w = 0;
    in_x = 0;
    in_y = 0;
    in_z = 0;
    send_idle = 0;
    recv_stall = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_quat(0, 0, 0, 0);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(1, 1, 1, 1);
    send_quat(1, 1, 1, 0);
    send_quat(3, 4, 0, 0);
    send_quat(-1, 0, 0, 0);
    send_quat(0, 0, 0, 16'sh8000);
    send_quat(16'sh5555, 16'shaaaa, 16'sh2aaa, 16'shd555);
    for (int i = 0; i < 12; i++)
      send_quat(corners[$urandom_range(6)], corners[$urandom_range(6)],
                corners[$urandom_range(6)], corners[$urandom_range(6)]);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? 84 : 0;
      recv_stall = (ph == 2 || ph == 3) ? 84 : 0;
      if (ph == 3) begin
        send_idle = 12;
        recv_stall = 12;
      end
      for (int i = 0; i < 385; i++) send_quat(pick_comp(), pick_comp(), pick_comp(), pick_comp());
    end
    in_valid <= 0;
    recv_stall = 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) $display("PASS quaternion_normalizer");
    else $display("FAIL quaternion_normalizer");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/qn_pkg.sv
rtl/qn_lane.sv
rtl/quaternion_normalizer.sv
tb/sv/quaternion_normalizer_checker.sv
tb/sv/quaternion_normalizer_tb.sv
